FILE: src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the bitmap block allocator
// Map geometry, command record passed from front to back, and the scan helper.
// ----------------------------------------------------------------------------
package bba_pkg;

    // map geometry
    localparam int MAX_BLOCKS  = 1024;
    localparam int MAX_REQUEST = 64;
    localparam int WORD_W      = 32;
    localparam int NUM_WORDS   = MAX_BLOCKS / WORD_W;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int WADDR_W     = $clog2(NUM_WORDS);

    // field widths
    localparam int BLK_W   = 10;
    localparam int CNT_W   = 7;
    localparam int LIMIT_W = 11;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic {
        OP_RESERVE = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [CNT_W-1:0] want;
        logic [BLK_W-1:0] blk;
        logic             eol;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REL_RD,
        S_ACK,
        S_RES_RD,
        S_SCAN,
        S_FULL
    } t_state;

    // lowest set bit of a word, zero when none is set
    function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: src/bba_if.sv
// ----------------------------------------------------------------------------
// bba_if: request and result channels of the bitmap block allocator
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bba_req_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [6:0] request_count;
    logic [9:0] block_number;
    logic       end_of_list;

    modport source (output valid, opcode, request_count, block_number, end_of_list,
                    input ready);
    modport sink   (input valid, opcode, request_count, block_number, end_of_list,
                    output ready);
endinterface

interface bba_rsp_if;
    logic       valid;
    logic       ready;
    logic [9:0] granted_block;
    logic       status;
    logic       last_result;

    modport source (output valid, granted_block, status, last_result, input ready);
    modport sink   (input valid, granted_block, status, last_result, output ready);
endinterface

FILE: src/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/bba_front.sv
// ----------------------------------------------------------------------------
// bba_front: request intake and command queue
// Takes request items, drops empty reserves, clamps the size, queues commands.
// ----------------------------------------------------------------------------
module bba_front
    import bba_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    bba_req_if.sink       i_req,
    output logic          o_cmd_valid,
    output t_cmd          o_cmd,
    input  logic          i_cmd_pop
);

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    t_cmd cmd;
    logic accept;
    logic push;
    logic pop;

    // classify the incoming item
    always_comb begin
        cmd.op   = t_op'(i_req.opcode);
        cmd.want = (i_req.request_count > CNT_W'(MAX_REQUEST)) ?
                   CNT_W'(MAX_REQUEST) : i_req.request_count;
        cmd.blk  = i_req.block_number;
        cmd.eol  = i_req.end_of_list;
    end

    assign i_req.ready = (r_cnt != QCNT_W'(QDEPTH));
    assign accept      = i_req.valid && i_req.ready;
    // a reserve for zero blocks does nothing at all
    assign push        = accept && !(cmd.op == OP_RESERVE && cmd.want == '0);
    assign pop         = i_cmd_pop && (r_cnt != '0);

    // queue pointers
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop) begin
            n_rp = (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

endmodule

FILE: src/bba_back.sv
// ----------------------------------------------------------------------------
// bba_back: map scan and release engine
// Holds the used map in word memory and produces result items one at a time.
// ----------------------------------------------------------------------------
module bba_back
    import bba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [LIMIT_W-1:0] i_limit,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_cmd_pop,
    bba_rsp_if.source          o_rsp
);

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [WADDR_W-1:0] r_w, n_w;
    logic [WORD_W-1:0]  r_word, n_word;
    logic [CNT_W-1:0]   r_found, n_found;
    logic [NUM_WORDS-1:0] r_row_vld;
    logic               r_rd_vld;

    logic               r_out_vld, n_out_vld;
    logic [BLK_W-1:0]   r_out_blk, n_out_blk;
    logic               r_out_status, n_out_status;
    logic               r_out_last, n_out_last;

    logic               wr_en;
    logic [WADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               rd_en;
    logic [WADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0]  rd_data;
    logic [WORD_W-1:0]  rd_word;

    logic               out_free;
    logic [WADDR_W:0]   lim_word;
    logic [BIT_W-1:0]   lim_bits;
    logic [WORD_W-1:0]  mask;
    logic [WORD_W-1:0]  cand;
    logic [BIT_W-1:0]   cand_idx;
    logic [WADDR_W:0]   nxt_w;
    logic               more;

    bba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // a row never written reads as all free
    assign rd_word  = r_rd_vld ? rd_data : '0;
    assign out_free = !r_out_vld || o_rsp.ready;

    // blocks at or above the limit count as used for the scan
    assign lim_word = i_limit[LIMIT_W-1:BIT_W];
    assign lim_bits = i_limit[BIT_W-1:0];
    always_comb begin
        if ({1'b0, r_w} < lim_word) begin
            mask = '1;
        end else if ({1'b0, r_w} == lim_word) begin
            mask = ~({WORD_W{1'b1}} << lim_bits);
        end else begin
            mask = '0;
        end
    end

    assign cand     = ~r_word & mask;
    assign cand_idx = first_set(cand);
    assign nxt_w    = {1'b0, r_w} + 1'b1;
    assign more     = ({nxt_w, {BIT_W{1'b0}}} < i_limit);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_w          = r_w;
        n_word       = r_word;
        n_found      = r_found;
        n_out_vld    = r_out_vld && !o_rsp.ready;
        n_out_blk    = r_out_blk;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        o_cmd_pop    = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_w;
        wr_data      = r_word;
        rd_en        = 1'b0;
        rd_addr      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_found   = '0;
                    n_w       = '0;
                    if (i_cmd.op == OP_RELEASE) begin
                        rd_en   = 1'b1;
                        rd_addr = i_cmd.blk[BLK_W-1:BIT_W];
                        n_state = S_REL_RD;
                    end else if (i_limit == '0) begin
                        n_state = S_FULL;
                    end else begin
                        rd_en   = 1'b1;
                        n_state = S_RES_RD;
                    end
                end
            end
            S_REL_RD: begin
                wr_en   = 1'b1;
                wr_addr = r_cmd.blk[BLK_W-1:BIT_W];
                wr_data = rd_word & ~(WORD_W'(1) << r_cmd.blk[BIT_W-1:0]);
                n_state = r_cmd.eol ? S_ACK : S_IDLE;
            end
            S_ACK: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_blk    = r_cmd.blk;
                    n_out_status = STATUS_OK;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RES_RD: begin
                n_word  = rd_word;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (cand != '0) begin
                    if (out_free) begin
                        n_word       = r_word | (WORD_W'(1) << cand_idx);
                        wr_en        = 1'b1;
                        wr_data      = n_word;
                        n_found      = r_found + 1'b1;
                        n_out_vld    = 1'b1;
                        n_out_blk    = {r_w, cand_idx};
                        n_out_status = STATUS_OK;
                        n_out_last   = (n_found == r_cmd.want);
                        if (n_found == r_cmd.want) begin
                            n_state = S_IDLE;
                        end
                    end
                end else if (more) begin
                    n_w     = nxt_w[WADDR_W-1:0];
                    rd_en   = 1'b1;
                    rd_addr = nxt_w[WADDR_W-1:0];
                    n_state = S_RES_RD;
                end else begin
                    n_state = S_FULL;
                end
            end
            S_FULL: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_blk    = '0;
                    n_out_status = STATUS_FULL;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_IDLE || r_state == S_SCAN) begin
            if (rd_en && r_state == S_IDLE && i_cmd.op != OP_RELEASE) begin
                rd_addr = '0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_row_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (wr_en) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_w          <= n_w;
        r_word       <= n_word;
        r_found      <= n_found;
        r_out_blk    <= n_out_blk;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        if (rd_en) begin
            r_rd_vld <= r_row_vld[rd_addr];
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.granted_block = r_out_blk;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.last_result   = r_out_last;

    // a full result always closes the item with block zero
    a_full_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status == STATUS_FULL) |-> (r_out_last && r_out_blk == '0))
        else $error("full result with wrong shape");

    // the scan never grants more blocks than were asked for
    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_found < r_cmd.want))
        else $error("scan past requested count");

    // a word read is always followed by a scan of it
    a_read_then_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES_RD) |=> (r_state == S_SCAN))
        else $error("word read not followed by scan");

    // a granted block lies below the limit
    a_grant_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && cand != '0) |-> ({1'b0, r_w, cand_idx} < i_limit))
        else $error("grant beyond configured block count");

endmodule

FILE: src/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator: first-fit swap block allocator over a used-bit map
// A release reads the map word that holds the block and writes it back with
// the bit cleared; the end of a release list then shows an acknowledgement.
// A reserve reads the map one 32-bit word at a time and grants one block per cycle while the result channel takes them.
// Throughput is set by the single scan engine: one item at a time.
// Reset (synchronous, active low) frees every block and sets the count to 1024.
// ----------------------------------------------------------------------------
module bitmap_block_allocator
    import bba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    bba_req_if.sink            i_req,
    bba_rsp_if.source          o_rsp
);

    logic [LIMIT_W-1:0] r_swap_block_count;
    logic [LIMIT_W-1:0] limit;
    logic               cmd_valid;
    t_cmd               cmd;
    logic               cmd_pop;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap_block_count <= LIMIT_W'(MAX_BLOCKS);
        end else if (i_cfg_we) begin
            r_swap_block_count <= i_cfg_wdata;
        end
    end

    // counts above the map size scan the whole map
    assign limit = (r_swap_block_count > LIMIT_W'(MAX_BLOCKS)) ?
                   LIMIT_W'(MAX_BLOCKS) : r_swap_block_count;

    bba_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    bba_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (limit),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_rsp       (o_rsp)
    );

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking regression of the bitmap block allocator
// Reserve and release items go through the request channel. Each accepted
// item is run through a shadow copy of the used map to queue its grants.
// Every result item is then compared against the oldest queued grant.
// Both channels idle at random, and the block count changes between phases.
// ----------------------------------------------------------------------------
module tb_top
    import bba_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 24;

    typedef struct packed {
        logic [BLK_W-1:0] blk;
        logic             status;
        logic             last;
    } t_grant;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_wdata;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    bitmap_block_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // shadow allocator state
    logic [MAX_BLOCKS-1:0] block_used;
    logic [LIMIT_W-1:0]    block_limit;

    t_cmd   cmd_queue[$];
    t_grant grants_due[$];
    t_cmd   cmd_on_bus;
    int     cycles = 0;
    int     errors = 0;
    logic   calm;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit, with a quiet window where neither side idles
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("bitmap_block_allocator regression: fail");
            $finish;
        end
    end
    assign calm = (cycles % 5000) >= 3500;

    // first-fit allocation over the shadow map, queueing the grants it causes
    function automatic void predict_grants(input t_cmd c);
        int     want;
        int     lim;
        int     found;
        t_grant g;
        if (c.op == OP_RELEASE) begin
            block_used[c.blk] = 1'b0;
            if (c.eol) begin
                grants_due.push_back('{blk: c.blk, status: STATUS_OK, last: 1'b1});
            end
            return;
        end
        want  = (c.want > MAX_REQUEST) ? MAX_REQUEST : int'(c.want);
        lim   = (block_limit > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_limit);
        found = 0;
        if (want == 0) begin
            return;
        end
        for (int b = 0; b < lim && found < want; b++) begin
            if (!block_used[b]) begin
                block_used[b] = 1'b1;
                grants_due.push_back('{blk: BLK_W'(b), status: STATUS_OK, last: 1'b0});
                found++;
            end
        end
        if (found == want) begin
            g = grants_due.pop_back();
            g.last = 1'b1;
            grants_due.push_back(g);
        end else begin
            grants_due.push_back('{blk: '0, status: STATUS_FULL, last: 1'b1});
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                predict_grants(cmd_on_bus);
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (cmd_queue.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
                    cmd_on_bus = cmd_queue.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.opcode        <= cmd_on_bus.op;
                    req_ch.request_count <= cmd_on_bus.want;
                    req_ch.block_number  <= cmd_on_bus.blk;
                    req_ch.end_of_list   <= cmd_on_bus.eol;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= calm || $urandom_range(99) >= 26;
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (grants_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result blk=%0d status=%0b last=%0b", $time,
                             rsp_ch.granted_block, rsp_ch.status, rsp_ch.last_result);
                end else if (rsp_ch.granted_block !== grants_due[0].blk ||
                             rsp_ch.status !== grants_due[0].status ||
                             rsp_ch.last_result !== grants_due[0].last) begin
                    errors++;
                    $display("%0t: mismatch expected %0d/%0b/%0b, actual %0d/%0b/%0b",
                             $time, grants_due[0].blk, grants_due[0].status,
                             grants_due[0].last, rsp_ch.granted_block, rsp_ch.status,
                             rsp_ch.last_result);
                    void'(grants_due.pop_front());
                end else begin
                    void'(grants_due.pop_front());
                end
            end
        end
    end

    function automatic void send(input t_op op, input int want, input int blk, input bit eol);
        cmd_queue.push_back('{op: op, want: CNT_W'(want), blk: BLK_W'(blk), eol: eol});
    endfunction

    // wait until the block has taken every item and returned every grant
    task automatic drain();
        while (cmd_queue.size() != 0 || req_ch.valid || grants_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_block_count(input int cnt);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= LIMIT_W'(cnt);
        block_limit = LIMIT_W'(cnt);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly reserves and release lists, some odd counts and loose releases
    task automatic queue_random(input int n);
        int made;
        int span;
        int r;
        int len;
        made = 0;
        span = (block_limit > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_limit);
        if (span == 0) begin
            span = 1;
        end
        while (made < n) begin
            r = $urandom_range(99);
            if (r < 55) begin
                r = $urandom_range(99);
                if (r < 70) begin
                    send(OP_RESERVE, $urandom_range(8, 1), 0, 1'($urandom_range(1)));
                    made++;
                end else if (r < 90) begin
                    send(OP_RESERVE, $urandom_range(MAX_REQUEST, 9), $urandom_range(1023), 0);
                    made++;
                end else if (r < 96) begin
                    send(OP_RESERVE, $urandom_range(127, MAX_REQUEST + 1), 0, 1);
                    made++;
                end else begin
                    send(OP_RESERVE, 0, $urandom_range(1023), 1);
                end
            end else if (r < 92) begin
                len = $urandom_range(4, 1);
                for (int i = 0; i < len; i++) begin
                    send(OP_RELEASE, $urandom_range(127),
                         ($urandom_range(99) < 80) ? $urandom_range(span - 1)
                                                   : $urandom_range(1023),
                         i == len - 1);
                    made++;
                end
            end else begin
                send(OP_RELEASE, $urandom_range(127), $urandom_range(1023),
                     1'($urandom_range(1)));
                made++;
            end
        end
    endtask

    int phase_counts[] = '{1024, 40, 1, 300, 2047, 8, 1023, 0, 64};

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = '0;
        req_ch.valid         = 1'b0;
        req_ch.opcode        = OP_RESERVE;
        req_ch.request_count = '0;
        req_ch.block_number  = '0;
        req_ch.end_of_list   = 1'b0;
        rsp_ch.ready         = 1'b0;
        block_used           = '0;
        block_limit          = LIMIT_W'(MAX_BLOCKS);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: smallest and largest requests, zero and oversized counts
        send(OP_RESERVE, 1, 0, 0);
        send(OP_RESERVE, MAX_REQUEST, 0, 0);
        send(OP_RESERVE, 0, 0, 0);
        send(OP_RESERVE, 127, 1023, 1);
        send(OP_RESERVE, 100, 0, 0);
        // release lists, only the end of a list is acknowledged
        send(OP_RELEASE, 0, 5, 0);
        send(OP_RELEASE, 0, 1023, 0);
        send(OP_RELEASE, 0, 0, 1);
        send(OP_RESERVE, 3, 0, 0);
        send(OP_RELEASE, 127, 1023, 1);
        send(OP_RELEASE, 0, 682, 1);
        send(OP_RELEASE, 0, 341, 1);
        drain();

        // nothing to allocate: every reserve reports full
        set_block_count(0);
        send(OP_RESERVE, 1, 0, 0);
        send(OP_RESERVE, MAX_REQUEST, 0, 0);
        send(OP_RELEASE, 0, 200, 1);
        drain();

        // count above the map size, fill the whole map, then partial grants
        set_block_count(2047);
        for (int i = 0; i < 16; i++) begin
            send(OP_RESERVE, MAX_REQUEST, 0, 0);
        end
        send(OP_RESERVE, 5, 0, 0);
        send(OP_RELEASE, 0, 1000, 0);
        send(OP_RELEASE, 0, 7, 1);
        send(OP_RESERVE, 5, 0, 0);
        drain();

        // single block map
        set_block_count(1);
        send(OP_RELEASE, 0, 0, 1);
        send(OP_RESERVE, 2, 0, 0);
        drain();

        // random phases, with a full pause halfway through each
        foreach (phase_counts[p]) begin
            set_block_count(phase_counts[p]);
            if (p == 0) begin
                // release every 64th block so the default size phase sees low block numbers
                for (int b = 0; b < MAX_BLOCKS; b += 64) begin
                    send(OP_RELEASE, 0, b, 0);
                end
            end
            queue_random(18);
            drain();
            queue_random(18);
            drain();
        end

        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("bitmap_block_allocator regression: pass");
        end else begin
            $display("bitmap_block_allocator regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
src/bba_pkg.sv
src/bba_if.sv
src/bba_ram.sv
src/bba_front.sv
src/bba_back.sv
src/bitmap_block_allocator.sv
tb/tb_top.sv
